[src/rws_pkg.sv]
// rws_pkg: shared types and constants for the roulette wheel selector
// no dependencies
package rws_pkg;
  localparam int MaxEntries = 1024;
  localparam int IdxW = 10;
  localparam int CntW = 11;
  localparam int FitW = 32;
  localparam int SumW = 42;
  localparam int FracW = 16;

  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_CLEAR  = 2'd1,
    CMD_SEL1   = 2'd2,
    CMD_SEL2   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    BK_IDLE  = 2'd0,
    BK_SCALE = 2'd1,
    BK_WALK  = 2'd2,
    BK_DONE  = 2'd3
  } bk_state_t;

  // item passed from front to back
  typedef struct packed {
    cmd_t              cmd;
    logic [FitW-1:0]   fitness;
    logic [FracW-1:0]  draw_a;
    logic [FracW-1:0]  draw_b;
  } job_t;

  // result item
  typedef struct packed {
    status_t          status;
    logic [CntW-1:0]  entry_count;
    logic             hit_b;
    logic             hit_a;
    logic [IdxW-1:0]  index_b;
    logic [IdxW-1:0]  index_a;
  } res_t;
endpackage

[src/roulette_wheel_selector.sv]
// roulette_wheel_selector: fitness-proportionate selection over a loaded table
// depends on rws_pkg, rws_front, rws_back
//
// Input stream: cmd 0 appends a fitness entry, 1 clears the table, 2 selects
// one index from draw_a, 3 selects two indices from draw_a and draw_b.
// Every input item yields exactly one result item on the output stream.
// A two-entry queue takes items while the back end is busy.
// Append, clear and select on an empty table: the back end registers the result
// as it takes the item, and takes one per cycle while its result slot is free.
// A select computes its thresholds in the SCALE state, then walks the table
// one entry per cycle out of a registered memory read, through the single
// read port of the 1024 x 32 table. The back end stays busy until the result
// is loaded into the result slot.
// Items are handled one at a time in the back end.
// Reset empties the table; stored values are kept but unreadable.
// When the receiver stalls, the result is held and the queue fills,
// then in_tready falls.
module roulette_wheel_selector (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,  // fitness[31:0], draw_a[47:32], draw_b[63:48]
  input  logic [1:0]  in_tuser,  // cmd[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata, // index_a[9:0], index_b[19:10], hit_a[20], hit_b[21],
                                 // entry_count[32:22], zero[39:33]
  output logic [1:0]  out_tuser  // status[1:0]
);
  rws_pkg::job_t in_job, q_job;
  rws_pkg::res_t res;
  logic q_valid, q_ready;

  assign in_job.cmd     = rws_pkg::cmd_t'(in_tuser);
  assign in_job.fitness = in_tdata[31:0];
  assign in_job.draw_a  = in_tdata[47:32];
  assign in_job.draw_b  = in_tdata[63:48];

  rws_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_tvalid), .in_ready(in_tready),
    .in_job(in_job), .q_valid(q_valid), .q_ready(q_ready), .q_job(q_job)
  );

  rws_back u_back (
    .clk(clk), .rst_n(rst_n), .j_valid(q_valid), .j_ready(q_ready), .j_job(q_job),
    .r_valid(out_tvalid), .r_ready(out_tready), .r_res(res)
  );

  assign out_tdata = {7'd0, res.entry_count, res.hit_b, res.hit_a, res.index_b, res.index_a};
  assign out_tuser = res.status;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[20] |-> {1'b0, out_tdata[9:0]} < out_tdata[32:22])
    else $error("hit index outside table");
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == rws_pkg::ST_EMPTY |-> out_tdata[21:0] == 22'h0)
    else $error("empty select carries an index");
endmodule

[src/rws_front.sv]
// rws_front: two-entry queue in front of the back end
// depends on rws_pkg
module rws_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  rws_pkg::job_t in_job,
  output logic          q_valid,
  input  logic          q_ready,
  output rws_pkg::job_t q_job
);
  rws_pkg::job_t buf_r [2];
  logic          wp_r, rp_r;
  logic [1:0]    cnt_r;

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_job    = buf_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (in_valid && in_ready) begin
        buf_r[wp_r] <= in_job;
        wp_r <= ~wp_r;
      end
      if (q_valid && q_ready) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, in_valid && in_ready} - {1'b0, q_valid && q_ready};
    end
  end
endmodule

[src/rws_back.sv]
// rws_back: table memory, totals and the sequential cumulative walk
// depends on rws_pkg
module rws_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          j_valid,
  output logic          j_ready,
  input  rws_pkg::job_t j_job,
  output logic          r_valid,
  input  logic          r_ready,
  output rws_pkg::res_t r_res
);
  logic [rws_pkg::FitW-1:0] mem [rws_pkg::MaxEntries];
  logic [rws_pkg::FitW-1:0] rd_r;

  rws_pkg::bk_state_t st_r, st_nxt;
  rws_pkg::job_t job_r;
  logic [rws_pkg::SumW-1:0] total_r, ta_r, tb_r, acc_r, span;
  logic [rws_pkg::FitW-1:0] first_r;
  logic [rws_pkg::CntW-1:0] cnt_r, pos_r;
  logic [rws_pkg::IdxW-1:0] ia_r, ib_r;
  logic ha_r, hb_r, rv_r, rv_nxt, rdv_r;
  rws_pkg::res_t res_r, res_nxt;
  logic [rws_pkg::SumW+rws_pkg::FracW-1:0] pa, pb;
  logic [rws_pkg::SumW-1:0] acc_n;
  logic take, full, pair, ha_n, hb_n, last;

  assign r_valid = rv_r;
  assign r_res   = res_r;
  assign take    = j_valid && j_ready;
  assign full    = cnt_r[rws_pkg::CntW-1];
  assign pair    = (job_r.cmd == rws_pkg::CMD_SEL2);
  assign span    = total_r - {{(rws_pkg::SumW-rws_pkg::FitW){1'b0}}, first_r};
  assign pa      = span * job_r.draw_a;
  assign pb      = span * job_r.draw_b;
  assign acc_n   = acc_r + {{(rws_pkg::SumW-rws_pkg::FitW){1'b0}}, rd_r};
  assign ha_n    = ha_r || (acc_n >= ta_r);
  assign hb_n    = hb_r || (acc_n >= tb_r);
  assign last    = (pos_r == cnt_r);

  // ready only when idle and the result slot is free
  always_comb begin
    j_ready = (st_r == rws_pkg::BK_IDLE) && (!rv_r || r_ready);
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      rws_pkg::BK_IDLE:
        if (take && (j_job.cmd == rws_pkg::CMD_SEL1 || j_job.cmd == rws_pkg::CMD_SEL2)
            && cnt_r != '0) st_nxt = rws_pkg::BK_SCALE;
      rws_pkg::BK_SCALE: st_nxt = rws_pkg::BK_WALK;
      rws_pkg::BK_WALK:
        if (rdv_r && (last || (ha_n && (!pair || hb_n)))) st_nxt = rws_pkg::BK_DONE;
      rws_pkg::BK_DONE:
        if (!rv_r || r_ready) st_nxt = rws_pkg::BK_IDLE;
      default: st_nxt = rws_pkg::BK_IDLE;
    endcase
  end

  // result slot: held while stalled, reloaded when a new result is ready
  always_comb begin
    rv_nxt  = rv_r && !r_ready;
    res_nxt = res_r;
    unique case (st_r)
      rws_pkg::BK_IDLE: if (take) begin
        res_nxt = '0;
        unique case (j_job.cmd)
          rws_pkg::CMD_APPEND: begin
            if (full) begin
              res_nxt.status = rws_pkg::ST_FULL;
              res_nxt.entry_count = cnt_r;
            end else begin
              res_nxt.entry_count = cnt_r + 1'b1;
            end
            rv_nxt = 1'b1;
          end
          rws_pkg::CMD_CLEAR: rv_nxt = 1'b1;
          default: begin
            if (cnt_r == '0) begin
              res_nxt.status = rws_pkg::ST_EMPTY;
              rv_nxt = 1'b1;
            end
          end
        endcase
      end
      rws_pkg::BK_DONE: if (!rv_r || r_ready) begin
        res_nxt.index_a = ia_r;
        res_nxt.hit_a = ha_r;
        res_nxt.index_b = pair ? ib_r : '0;
        res_nxt.hit_b = pair && hb_r;
        res_nxt.entry_count = cnt_r;
        res_nxt.status = rws_pkg::ST_OK;
        rv_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (take && j_job.cmd == rws_pkg::CMD_APPEND && !full)
      mem[cnt_r[rws_pkg::IdxW-1:0]] <= j_job.fitness;
    rd_r <= mem[pos_r[rws_pkg::IdxW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= rws_pkg::BK_IDLE;
      total_r <= '0;
      first_r <= '0;
      cnt_r   <= '0;
      rv_r    <= 1'b0;
      rdv_r   <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      rv_r  <= rv_nxt;
      res_r <= res_nxt;
      unique case (st_r)
        rws_pkg::BK_IDLE: if (take) begin
          job_r <= j_job;
          unique case (j_job.cmd)
            rws_pkg::CMD_APPEND: begin
              if (!full) begin
                if (cnt_r == '0) first_r <= j_job.fitness;
                total_r <= total_r + {{(rws_pkg::SumW-rws_pkg::FitW){1'b0}}, j_job.fitness};
                cnt_r <= cnt_r + 1'b1;
              end
            end
            rws_pkg::CMD_CLEAR: begin
              cnt_r <= '0;
              total_r <= '0;
              first_r <= '0;
            end
            default: ;
          endcase
        end
        rws_pkg::BK_SCALE: begin
          ta_r <= {{(rws_pkg::SumW-rws_pkg::FitW){1'b0}}, first_r}
                  + pa[rws_pkg::SumW+rws_pkg::FracW-1:rws_pkg::FracW];
          tb_r <= {{(rws_pkg::SumW-rws_pkg::FitW){1'b0}}, first_r}
                  + pb[rws_pkg::SumW+rws_pkg::FracW-1:rws_pkg::FracW];
          acc_r <= pair ? {{(rws_pkg::SumW-rws_pkg::FitW){1'b0}}, first_r} : '0;
          ha_r <= 1'b0;
          hb_r <= 1'b0;
          ia_r <= pair ? '0 : cnt_r[rws_pkg::IdxW-1:0] - 1'b1;
          ib_r <= '0;
          pos_r <= '0;
          rdv_r <= 1'b0;
        end
        rws_pkg::BK_WALK: begin
          if (!rdv_r) begin
            rdv_r <= 1'b1;
            pos_r <= pos_r + 1'b1;
          end else begin
            acc_r <= acc_n;
            if (!ha_r && ha_n) ia_r <= pos_r[rws_pkg::IdxW-1:0] - 1'b1;
            if (!hb_r && hb_n) ib_r <= pos_r[rws_pkg::IdxW-1:0] - 1'b1;
            ha_r <= ha_n;
            hb_r <= hb_n;
            pos_r <= pos_r + 1'b1;
          end
        end
        rws_pkg::BK_DONE: if (!rv_r || r_ready) begin
          rdv_r <= 1'b0;
        end
        default: ;
      endcase
    end
  end
endmodule

[verif/roulette_wheel_selector_tb.sv]
// roulette_wheel_selector_tb: self-checking bench for the roulette wheel selector
// depends on rws_pkg and roulette_wheel_selector; runs directed rows, random
// load/select sequences under idle/stall phases, then a 30-entry table walk
`timescale 1ns / 100ps

module roulette_wheel_selector_tb;

  typedef struct {
    logic [rws_pkg::IdxW-1:0] index_a;
    logic [rws_pkg::IdxW-1:0] index_b;
    logic                     hit_a;
    logic                     hit_b;
    logic [rws_pkg::CntW-1:0] entry_count;
    rws_pkg::status_t         status;
  } pick_t;

  typedef struct {
    rws_pkg::cmd_t cmd;
    logic [31:0]   fitness;
    logic [15:0]   draw_a;
    logic [15:0]   draw_b;
    bit            typed;
    pick_t         want;
  } row_t;

  localparam int WatchdogLimit = 60000;
  localparam int NumRows = 19;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic [1:0]  out_tuser;

  // predictor state
  logic [rws_pkg::FitW-1:0] wheel [rws_pkg::MaxEntries];
  logic [63:0]              wheel_total;
  logic [63:0]              wheel_first;
  int unsigned              wheel_count;

  pick_t pending_picks[$];
  int    errors = 0;
  int    idle_pct = 0;
  int    stall_pct = 0;
  int    quiet_cycles = 0;

  roulette_wheel_selector i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
  endfunction

  // first + floor((total - first) * draw / 2^16)
  function automatic logic [63:0] spin_point(logic [15:0] draw);
    logic [79:0] prod;
    prod = {16'd0, wheel_total - wheel_first} * {64'd0, draw};
    return wheel_first + prod[79:rws_pkg::FracW];
  endfunction

  function automatic pick_t predict_pick(rws_pkg::cmd_t cmd, logic [31:0] fit,
                                         logic [15:0] da, logic [15:0] db);
    pick_t p;
    logic [63:0] ta, tb, acc;
    p = '{default: '0, status: rws_pkg::ST_OK};
    case (cmd)
      rws_pkg::CMD_APPEND: begin
        if (wheel_count >= rws_pkg::MaxEntries) begin
          p.status = rws_pkg::ST_FULL;
        end else begin
          if (wheel_count == 0) wheel_first = {32'd0, fit};
          wheel[wheel_count] = fit;
          wheel_count++;
          wheel_total = sat_sum(wheel_total, {32'd0, fit});
        end
      end
      rws_pkg::CMD_CLEAR: begin
        wheel_count = 0;
        wheel_total = '0;
        wheel_first = '0;
      end
      default: begin
        if (wheel_count == 0) begin
          p.status = rws_pkg::ST_EMPTY;
        end else if (cmd == rws_pkg::CMD_SEL1) begin
          ta = spin_point(da);
          acc = '0;
          p.index_a = rws_pkg::IdxW'(wheel_count - 1);
          for (int j = 0; j < wheel_count; j++) begin
            acc = sat_sum(acc, {32'd0, wheel[j]});
            if (acc >= ta) begin
              p.index_a = rws_pkg::IdxW'(j);
              p.hit_a = 1'b1;
              break;
            end
          end
        end else begin
          ta = spin_point(da);
          tb = spin_point(db);
          // pair walk starts from the first fitness
          acc = wheel_first;
          for (int j = 0; j < wheel_count; j++) begin
            acc = sat_sum(acc, {32'd0, wheel[j]});
            if (!p.hit_a && acc >= ta) begin
              p.index_a = rws_pkg::IdxW'(j);
              p.hit_a = 1'b1;
            end
            if (!p.hit_b && acc >= tb) begin
              p.index_b = rws_pkg::IdxW'(j);
              p.hit_b = 1'b1;
            end
            if (p.hit_a && p.hit_b) break;
          end
        end
      end
    endcase
    p.entry_count = rws_pkg::CntW'(wheel_count);
    return p;
  endfunction

  task automatic send_item(rws_pkg::cmd_t cmd, logic [31:0] fit, logic [15:0] da,
                           logic [15:0] db, bit typed, pick_t want);
    pick_t p;
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {db, da, fit};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    p = predict_pick(cmd, fit, da, db);
    if (typed) p = want;
    pending_picks = {pending_picks, p};
  endtask

  function automatic logic [31:0] rand_fitness();
    case ($urandom_range(5))
      0: return '0;
      1: return $urandom_range(255);
      2: return $urandom_range(32'h0003_0000);
      3: return 32'hFFFF_FFFF - $urandom_range(15);
      default: return $urandom;
    endcase
  endfunction

  task automatic random_item(int max_load);
    rws_pkg::cmd_t cmd;
    logic [15:0] da, db;
    pick_t none;
    none = '{default: '0, status: rws_pkg::ST_OK};
    da = 16'($urandom);
    db = 16'($urandom);
    case ($urandom_range(19))
      0:         cmd = rws_pkg::CMD_CLEAR;
      1, 2, 3:   cmd = (wheel_count < max_load) ? rws_pkg::CMD_APPEND : rws_pkg::CMD_SEL1;
      4, 5, 6:   cmd = rws_pkg::CMD_APPEND;
      7, 8:      cmd = rws_pkg::CMD_SEL1;
      default:   cmd = ($urandom_range(1)) ? rws_pkg::CMD_SEL2 : rws_pkg::CMD_SEL1;
    endcase
    if (cmd == rws_pkg::CMD_APPEND && wheel_count >= max_load) cmd = rws_pkg::CMD_CLEAR;
    if ($urandom_range(7) == 0) da = $urandom_range(1) ? 16'hFFFF : 16'h0000;
    send_item(cmd, rand_fitness(), da, db, 1'b0, none);
  endtask

  // result checker and stall control
  always @(posedge clk) begin
    pick_t w;
    logic  bad;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_picks.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result item: data %h user %h",
                                   out_tdata, out_tuser);
      end else begin
        w = pending_picks.pop_front();
        bad = out_tdata[9:0] !== w.index_a || out_tdata[19:10] !== w.index_b ||
              out_tdata[20] !== w.hit_a || out_tdata[21] !== w.hit_b ||
              out_tdata[32:22] !== w.entry_count || out_tuser !== w.status;
        if (bad) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp ia=%0d ib=%0d ha=%0b hb=%0b cnt=%0d st=%0d",
                     w.index_a, w.index_b, w.hit_a, w.hit_b, w.entry_count, w.status,
                     " | act ia=%0d ib=%0d ha=%0b hb=%0b cnt=%0d st=%0d",
                     out_tdata[9:0], out_tdata[19:10], out_tdata[20],
                     out_tdata[21], out_tdata[32:22], out_tuser);
        end
      end
    end
    out_tready <= !(stall_pct > 0 && $urandom_range(99) < stall_pct);
  end

  // watchdog on cycles with no item moving on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (rst_n) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    row_t rows [NumRows];
    pick_t none;
    pick_t empty_pick;
    none = '{default: '0, status: rws_pkg::ST_OK};
    empty_pick = '{default: '0, status: rws_pkg::ST_EMPTY};
    wheel_count = 0;
    wheel_total = '0;
    wheel_first = '0;

    rows = '{
      '{rws_pkg::CMD_SEL1,   32'h0,         16'hFFFF, 16'h0,    1'b1, empty_pick},
      '{rws_pkg::CMD_SEL2,   32'h0,         16'hFFFF, 16'hFFFF, 1'b1, empty_pick},
      '{rws_pkg::CMD_CLEAR,  32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b1, none},
      '{rws_pkg::CMD_APPEND, 32'hFFFF_FFFF, 16'h0,    16'h0,    1'b1,
        '{'0, '0, 1'b0, 1'b0, 11'd1, rws_pkg::ST_OK}},
      '{rws_pkg::CMD_APPEND, 32'h0,         16'h0,    16'h0,    1'b1,
        '{'0, '0, 1'b0, 1'b0, 11'd2, rws_pkg::ST_OK}},
      '{rws_pkg::CMD_APPEND, 32'h1,         16'h0,    16'h0,    1'b1,
        '{'0, '0, 1'b0, 1'b0, 11'd3, rws_pkg::ST_OK}},
      // zero draw lands on the first fitness itself
      '{rws_pkg::CMD_SEL1,   32'h0,         16'h0,    16'h0,    1'b1,
        '{10'd0, '0, 1'b1, 1'b0, 11'd3, rws_pkg::ST_OK}},
      '{rws_pkg::CMD_SEL1,   32'h0,         16'hFFFF, 16'h0,    1'b0, none},
      '{rws_pkg::CMD_SEL2,   32'h0,         16'h0,    16'hFFFF, 1'b0, none},
      '{rws_pkg::CMD_SEL2,   32'h0,         16'hFFFF, 16'h0,    1'b0, none},
      '{rws_pkg::CMD_CLEAR,  32'h0,         16'h0,    16'h0,    1'b1, none},
      '{rws_pkg::CMD_SEL2,   32'h0,         16'h1234, 16'h8000, 1'b1, empty_pick},
      '{rws_pkg::CMD_APPEND, 32'h0,         16'h0,    16'h0,    1'b0, none},
      '{rws_pkg::CMD_SEL1,   32'h0,         16'hFFFF, 16'h0,    1'b1,
        '{10'd0, '0, 1'b1, 1'b0, 11'd1, rws_pkg::ST_OK}},
      '{rws_pkg::CMD_APPEND, 32'h0001_0000, 16'h0,    16'h0,    1'b0, none},
      '{rws_pkg::CMD_APPEND, 32'h8000_0000, 16'h0,    16'h0,    1'b0, none},
      '{rws_pkg::CMD_SEL2,   32'h0,         16'h5555, 16'hAAAA, 1'b0, none},
      '{rws_pkg::CMD_SEL1,   32'h0,         16'h8000, 16'h0,    1'b0, none},
      '{rws_pkg::CMD_CLEAR,  32'h0,         16'h0,    16'h0,    1'b1, none}
    };

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i])
      send_item(rows[i].cmd, rows[i].fitness, rows[i].draw_a, rows[i].draw_b,
                rows[i].typed, rows[i].want);

    // random load/select sequences over four idle/stall phases
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 63; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 63; end
        default: begin idle_pct = 16; stall_pct = 16; end
      endcase
      for (int n = 0; n < 130; n++) random_item(ph == 3 ? 60 : 24);
    end

    // load a 30-entry table, then walk it end to end
    idle_pct = 0;
    stall_pct = 16;
    send_item(rws_pkg::CMD_CLEAR, '0, '0, '0, 1'b0, none);
    for (int n = 0; n < 30; n++)
      send_item(rws_pkg::CMD_APPEND, $urandom_range(65535), '0, '0, 1'b0, none);
    for (int n = 0; n < 12; n++) begin
      if (n < 2) send_item(rws_pkg::CMD_SEL1, '0, 16'hFFFF, '0, 1'b0, none);
      else send_item(n[0] ? rws_pkg::CMD_SEL2 : rws_pkg::CMD_SEL1, '0,
                     16'($urandom), 16'($urandom), 1'b0, none);
    end
    send_item(rws_pkg::CMD_CLEAR, '0, '0, '0, 1'b0, none);
    in_tvalid <= 1'b0;

    while (pending_picks.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

[filelist.f]
src/rws_pkg.sv
src/rws_front.sv
src/rws_back.sv
src/roulette_wheel_selector.sv
verif/roulette_wheel_selector_tb.sv
